// File: sv/sbc_pkg.sv
// Shared types, constants and word functions for the SIMON block cipher.
package sbc_pkg;

  localparam int WORD_W    = 64;
  localparam int KEY_WORDS = 4;
  localparam int ZSEQ_LEN  = 62;
  localparam int ZIDX_W    = 6;
  localparam int NROUNDS_W = 7;

  // Configuration register indexes (byte address is 8 * index).
  localparam logic [2:0] REG_VARIANT = 3'd0;
  localparam logic [2:0] REG_KEY0    = 3'd1;
  localparam logic [2:0] REG_KEY1    = 3'd2;
  localparam logic [2:0] REG_KEY2    = 3'd3;
  localparam logic [2:0] REG_KEY3    = 3'd4;
  localparam logic [2:0] REG_DECRYPT = 3'd5;

  typedef struct packed {
    logic [WORD_W-1:0] half_high;
    logic [WORD_W-1:0] half_low;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_high;
    logic [WORD_W-1:0] result_low;
  } out_item_t;

  // Per-variant shape: word bits, four-key-word flag, round count, z sequence.
  typedef struct packed {
    logic [NROUNDS_W-1:0] wbits;
    logic                 m4;
    logic [NROUNDS_W-1:0] nrounds;
    logic [2:0]           zsel;
  } shape_t;

  // Character j of a sequence string sits at bit ZSEQ_LEN-1-j.
  localparam logic [ZSEQ_LEN-1:0] ZSEQ [5] = '{
    62'b11111010001001010110000111001101111101000100101011000011100110,
    62'b10001110111110010011000010110101000111011111001001100001011010,
    62'b10101111011100000011010010011000101000010001111110010110110011,
    62'b11011011101011000110010111100000010010001010011100110100001111,
    62'b11010001111001101011011000100000010111000011001010010011101111
  };

  function automatic shape_t shape_of(input logic [2:0] v);
    shape_t s;
    case (v)
      3'd0:    s = '{wbits: 7'd16, m4: 1'b1, nrounds: 7'd32, zsel: 3'd0};
      3'd1:    s = '{wbits: 7'd24, m4: 1'b0, nrounds: 7'd36, zsel: 3'd0};
      3'd2:    s = '{wbits: 7'd24, m4: 1'b1, nrounds: 7'd36, zsel: 3'd1};
      3'd3:    s = '{wbits: 7'd32, m4: 1'b1, nrounds: 7'd44, zsel: 3'd3};
      3'd4:    s = '{wbits: 7'd48, m4: 1'b0, nrounds: 7'd54, zsel: 3'd3};
      3'd5:    s = '{wbits: 7'd64, m4: 1'b0, nrounds: 7'd69, zsel: 3'd3};
      default: s = '{wbits: 7'd64, m4: 1'b1, nrounds: 7'd72, zsel: 3'd4};
    endcase
    return s;
  endfunction

  function automatic logic [WORD_W-1:0] word_mask(input logic [NROUNDS_W-1:0] wbits);
    logic [WORD_W-1:0] m;
    case (wbits)
      7'd16:   m = 64'h0000_0000_0000_FFFF;
      7'd24:   m = 64'h0000_0000_00FF_FFFF;
      7'd32:   m = 64'h0000_0000_FFFF_FFFF;
      7'd48:   m = 64'h0000_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Rotate left by a fixed amount within a fixed width.
  function automatic logic [WORD_W-1:0] rotl_fix(input logic [WORD_W-1:0] v,
                                                 input int r, input int w);
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] vm;
    m  = (w >= WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
    vm = v & m;
    return ((vm << r) | (vm >> (w - r))) & m;
  endfunction

  function automatic logic [WORD_W-1:0] rotl_w(input logic [WORD_W-1:0] v, input int r,
                                               input logic [NROUNDS_W-1:0] wbits);
    logic [WORD_W-1:0] o;
    case (wbits)
      7'd16:   o = rotl_fix(v, r, 16);
      7'd24:   o = rotl_fix(v, r, 24);
      7'd32:   o = rotl_fix(v, r, 32);
      7'd48:   o = rotl_fix(v, r, 48);
      default: o = rotl_fix(v, r, 64);
    endcase
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] rotr_w(input logic [WORD_W-1:0] v, input int r,
                                               input logic [NROUNDS_W-1:0] wbits);
    logic [WORD_W-1:0] o;
    case (wbits)
      7'd16:   o = rotl_fix(v, 16 - r, 16);
      7'd24:   o = rotl_fix(v, 24 - r, 24);
      7'd32:   o = rotl_fix(v, 32 - r, 32);
      7'd48:   o = rotl_fix(v, 48 - r, 48);
      default: o = rotl_fix(v, 64 - r, 64);
    endcase
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] v,
                                                input logic [NROUNDS_W-1:0] wbits);
    return (rotl_w(v, 1, wbits) & rotl_w(v, 8, wbits)) ^ rotl_w(v, 2, wbits);
  endfunction

  function automatic logic z_bit(input logic [2:0] zsel, input logic [ZIDX_W-1:0] zidx);
    logic [ZSEQ_LEN-1:0] s;
    case (zsel)
      3'd0:    s = ZSEQ[0];
      3'd1:    s = ZSEQ[1];
      3'd2:    s = ZSEQ[2];
      3'd3:    s = ZSEQ[3];
      default: s = ZSEQ[4];
    endcase
    return s[6'd61 - zidx];
  endfunction

endpackage

// File: sv/sbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 72
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sbc_key_sched.sv
// Round key expansion sequencer: one round key written to the store per cycle.
module sbc_key_sched
  import sbc_pkg::*;
#(
  parameter int MAX_ROUNDS = 72
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  shape_t                              shape_i,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0]     rounds_i,
  input  logic [KEY_WORDS-1:0][WORD_W-1:0]    key_i,
  output logic                                busy_o,
  output logic                                we_o,
  output logic [$clog2(MAX_ROUNDS)-1:0]       waddr_o,
  output logic [WORD_W-1:0]                   wdata_o
);

  localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);
  localparam int RIDX_W = $clog2(MAX_ROUNDS);

  logic                    busy_q, busy_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [ZIDX_W-1:0]       zidx_q, zidx_d;
  // win_q[3] is key i-1, win_q[0] is key i-4.
  logic [3:0][WORD_W-1:0]  win_q, win_d;

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] t0, t1, t2, kim, gen, new_key;
  logic              from_key;

  always_comb begin
    mask     = word_mask(shape_i.wbits);
    from_key = idx_q < (shape_i.m4 ? CNT_W'(4) : CNT_W'(3));
    t0       = rotr_w(win_q[3], 3, shape_i.wbits);
    t1       = shape_i.m4 ? (t0 ^ win_q[1]) : t0;
    t2       = t1 ^ rotr_w(t1, 1, shape_i.wbits);
    kim      = shape_i.m4 ? win_q[0] : win_q[1];
    gen      = (~kim & mask) ^ t2 ^ {{(WORD_W-1){1'b0}}, z_bit(shape_i.zsel, zidx_q)}
               ^ 64'd3;
    new_key  = from_key ? (key_i[idx_q[1:0]] & mask) : gen;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    zidx_d = zidx_q;
    win_d  = win_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      zidx_d = '0;
    end else if (busy_q) begin
      win_d = {new_key, win_q[3:1]};
      idx_d = idx_q + CNT_W'(1);
      if (!from_key) begin
        zidx_d = (zidx_q == ZIDX_W'(ZSEQ_LEN - 1)) ? '0 : zidx_q + ZIDX_W'(1);
      end
      if (idx_q == rounds_i - CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      zidx_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      zidx_q <= zidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign busy_o  = busy_q;
  assign we_o    = busy_q && !start_i;
  assign waddr_o = idx_q[RIDX_W-1:0];
  assign wdata_o = new_key;

endmodule

// File: sv/sbc_round_core.sv
// Shared SIMON round unit with its round sequencer and output register.
module sbc_round_core
  import sbc_pkg::*;
#(
  parameter int MAX_ROUNDS = 72
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  in_item_t                          item_i,
  input  shape_t                            shape_i,
  input  logic                              decrypt_i,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0]   rounds_i,
  input  logic [WORD_W-1:0]                 key_i,
  output logic [$clog2(MAX_ROUNDS)-1:0]     raddr_o,
  output logic                              busy_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output out_item_t                         out_data_o
);

  localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);
  localparam int RIDX_W = $clog2(MAX_ROUNDS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  rnd_q, rnd_d;
  logic [WORD_W-1:0] x_q, x_d, y_q, y_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [WORD_W-1:0] mask;
  logic [CNT_W-1:0]  rnd_nxt;
  logic              last;
  logic [CNT_W-1:0]  key_idx;

  always_comb begin
    mask    = word_mask(shape_i.wbits);
    rnd_nxt = rnd_q + CNT_W'(1);
    last    = (rnd_nxt == rounds_i);
    // Key index for the round about to run next cycle.
    if (state_q == ST_RUN) begin
      if (last) begin
        key_idx = '0;
      end else begin
        key_idx = decrypt_i ? (rounds_i - CNT_W'(1) - rnd_nxt) : rnd_nxt;
      end
    end else begin
      key_idx = decrypt_i ? (rounds_i - CNT_W'(1)) : '0;
    end
  end

  assign raddr_o = key_idx[RIDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    x_d         = x_q;
    y_d         = y_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d     = item_i.half_high & mask;
          y_d     = item_i.half_low & mask;
          rnd_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (decrypt_i) begin
          y_d = x_q ^ round_f(y_q, shape_i.wbits) ^ key_i;
          x_d = y_q;
        end else begin
          x_d = y_q ^ round_f(x_q, shape_i.wbits) ^ key_i;
          y_d = x_q;
        end
        rnd_d = rnd_nxt;
        if (last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // Hold the finished block until the output register frees up.
        if (!out_valid_q || !out_stall_i) begin
          out_d       = '{result_high: x_q, result_low: y_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    out_q <= out_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/simon_block_cipher_top.sv
// Top level of the SIMON block cipher: register file, key store and round unit.
//
// SIMON block cipher, one 2n-bit block per request, in any of seven sizes
// (32/64, 48/72, 48/96, 64/128, 96/144, 128/192, 128/256) chosen by the
// variant register. Words travel in the low n bits of 64-bit fields; upper
// bits of inputs and keys are ignored and result bits above n read zero.
// Every write to a listed register (and reset) starts a key expansion that
// fills the round key store with one key per cycle; the input channel
// stalls while it runs. An accepted block runs through the single shared
// round unit, which runs one Feistel round per cycle with keys read one per
// cycle from the store, and the finished block then moves into the output
// register. The next request is accepted once the finished block has moved
// into the output register, even while that result waits to be taken.
// Decrypt mode walks the round keys in reverse. Write registers only while
// the block is idle: at byte address 8*i, 64-bit data, pready always high.
module simon_block_cipher_top
  import sbc_pkg::*;
#(
  parameter int MAX_ROUNDS = 72
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Block request channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_item_t      in_data_i,
  // Result channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_item_t     out_data_o,
  // Configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);
  localparam int RIDX_W = $clog2(MAX_ROUNDS);

  // Configuration registers
  logic [2:0]                       variant_q;
  logic [KEY_WORDS-1:0][WORD_W-1:0] key_q;
  logic                             decrypt_q;
  logic                             rekey_q;

  logic       wr_en;
  logic [2:0] reg_idx;
  logic       reg_hit;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Only writes to a listed register change the key schedule.
  always_comb begin
    case (reg_idx)
      REG_VARIANT, REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_DECRYPT: reg_hit = 1'b1;
      default: reg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= '0;
      key_q     <= '0;
      decrypt_q <= 1'b0;
      rekey_q   <= 1'b1;  // expand the all-zero key right after reset
    end else begin
      rekey_q <= wr_en && reg_hit;
      if (wr_en) begin
        case (reg_idx)
          REG_VARIANT: variant_q <= pwdata[2:0];
          REG_KEY0:    key_q[0]  <= pwdata;
          REG_KEY1:    key_q[1]  <= pwdata;
          REG_KEY2:    key_q[2]  <= pwdata;
          REG_KEY3:    key_q[3]  <= pwdata;
          REG_DECRYPT: decrypt_q <= pwdata[0];
          default:     ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VARIANT: prdata = {61'd0, variant_q};
      REG_KEY0:    prdata = key_q[0];
      REG_KEY1:    prdata = key_q[1];
      REG_KEY2:    prdata = key_q[2];
      REG_KEY3:    prdata = key_q[3];
      REG_DECRYPT: prdata = {63'd0, decrypt_q};
      default:     prdata = '0;
    endcase
  end

  // Shape of the selected variant; clip the round count to the store depth.
  shape_t            shape;
  logic [CNT_W-1:0]  rounds;

  always_comb begin
    shape  = shape_of(variant_q);
    rounds = (shape.nrounds > NROUNDS_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS)
                                                      : CNT_W'(shape.nrounds);
  end

  // Round key store
  logic                 ks_busy;
  logic                 ks_we;
  logic [RIDX_W-1:0]    ks_waddr;
  logic [WORD_W-1:0]    ks_wdata;
  logic [RIDX_W-1:0]    rk_raddr;
  logic [WORD_W-1:0]    rk_rdata;

  sbc_key_sched #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_key_sched (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rekey_q),
    .shape_i (shape),
    .rounds_i(rounds),
    .key_i   (key_q),
    .busy_o  (ks_busy),
    .we_o    (ks_we),
    .waddr_o (ks_waddr),
    .wdata_o (ks_wdata)
  );

  sbc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ROUNDS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ks_we),
    .waddr_i(ks_waddr),
    .wdata_i(ks_wdata),
    .raddr_i(rk_raddr),
    .rdata_o(rk_rdata)
  );

  // Round unit
  logic core_busy;
  logic accept;

  // Stall while a block is in flight, keys are being rebuilt, or a write lands.
  assign in_stall_o = core_busy || ks_busy || rekey_q || wr_en;
  assign accept     = in_valid_i && !in_stall_o;

  sbc_round_core #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_round_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .item_i     (in_data_i),
    .shape_i    (shape),
    .decrypt_i  (decrypt_q),
    .rounds_i   (rounds),
    .key_i      (rk_rdata),
    .raddr_o    (rk_raddr),
    .busy_o     (core_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
